// ===== hdl/tkc_pkg.sv =====
`default_nettype none

package tkc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned LenW  = 5;

  localparam logic [WordW-1:0] SIGN64        = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] BYTE_FLIPS    = 64'h8080_8080_8080_8080;
  localparam logic [WordW-1:0] UUID_MID_MASK = 64'h0FFF_FFFF_FFFF_F000;
  localparam logic [WordW-1:0] TIME_MID_MASK = 64'h0000_FFFF_0000_0000;
  localparam logic [LenW-1:0]  MAX_BYTES     = 5'd16;

  typedef enum logic [3:0] {
    MODE_BOOL     = 4'd0,
    MODE_I8       = 4'd1,
    MODE_I16      = 4'd2,
    MODE_I32      = 4'd3,
    MODE_I64      = 4'd4,
    MODE_LONG     = 4'd5,
    MODE_FLOAT    = 4'd6,
    MODE_DOUBLE   = 4'd7,
    MODE_PASS4    = 4'd8,
    MODE_PASS8    = 4'd9,
    MODE_UUID     = 4'd10,
    MODE_TIMEUUID = 4'd11
  } mode_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_SHORT = 1'b1
  } status_e;

  typedef struct packed {
    logic [3:0]       mode;
    logic             direction;
    logic [WordW-1:0] in_hi;
    logic [WordW-1:0] in_lo;
    logic [LenW-1:0]  in_length;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] out_hi;
    logic [WordW-1:0] out_lo;
    logic [LenW-1:0]  out_length;
    logic             status;
  } out_t;

  // varlen long unit result, before length check and masking
  typedef struct packed {
    logic [WordW-1:0] oh;
    logic [WordW-1:0] ol;
    logic [LenW-1:0]  olen;
    logic [LenW-1:0]  need;
  } long_res_t;

  function automatic logic [WordW-1:0] msb_to_cmp(input logic [WordW-1:0] m);
    msb_to_cmp = (m << 48) | ((m << 16) & TIME_MID_MASK) | (m >> 32);
  endfunction

  function automatic logic [WordW-1:0] msb_from_cmp(input logic [WordW-1:0] m);
    msb_from_cmp = (m << 32) | ((m >> 16) & 64'h0000_0000_FFFF_0000) | (m >> 48);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tkc_long.sv =====
`default_nettype none

module tkc_long (
  input  logic [tkc_pkg::WordW-1:0] hi_i,
  input  logic [tkc_pkg::WordW-1:0] lo_i,
  input  logic                      dec_i,
  output tkc_pkg::long_res_t        res_o
);
  import tkc_pkg::*;

  // encode side
  logic             neg;
  logic [WordW-1:0] ev;
  logic [3:0]       enc_nb;
  logic [2:0]       esh;
  logic [2:0]       epos;
  logic [7:0]       emask;
  logic [WordW-1:0] ew;
  logic [WordW-1:0] eoh;
  logic [WordW-1:0] w9;

  always_comb begin
    neg = hi_i[63];
    ev  = hi_i ^ {WordW{neg}};
    // one byte per started 7-bit group, sign bit included
    enc_nb = 4'd1;
    for (int k = 1; k <= 8; k++) begin
      if (|(ev >> (7 * k - 1))) begin
        enc_nb = enc_nb + 4'd1;
      end
    end
    esh   = 3'(4'd8 - enc_nb);
    epos  = 3'(enc_nb - 4'd1);
    emask = 8'(8'hFF << esh);
    ew    = (ev | ({56'd0, emask} << {epos, 3'b000})) ^ {WordW{neg}};
    eoh   = ew << {esh, 3'b000};
    w9    = (ev | SIGN64) ^ {WordW{neg}};
  end

  // decode side
  logic [7:0]       b;
  logic             pos;
  logic [7:0]       x;
  logic [3:0]       dec_nb;
  logic             long9;
  logic [2:0]       dsh;
  logic [2:0]       dpos;
  logic [7:0]       dmask;
  logic [WordW-1:0] dv;

  always_comb begin
    b   = hi_i[63:56];
    pos = b[7];
    x   = b ^ {8{pos}};
    // x[7] is always clear, so the count is 1..8
    dec_nb = 4'd8;
    for (int i = 0; i < 7; i++) begin
      if (x[i]) begin
        dec_nb = 4'(7 - i);
      end
    end
    long9 = (dec_nb == 4'd8) && (hi_i[55] == pos);
    dsh   = 3'(4'd8 - dec_nb);
    dpos  = 3'(dec_nb - 4'd1);
    dmask = 8'(8'hFF << dsh);
    dv    = (hi_i >> {dsh, 3'b000}) ^ ({56'd0, dmask} << {dpos, 3'b000});
    // negative values shorter than 8 bytes get sign extension
    if (!pos && (dec_nb != 4'd8)) begin
      dv = dv | ({WordW{1'b1}} << {dec_nb[2:0], 3'b000});
    end
  end

  always_comb begin
    if (dec_i) begin
      res_o.olen = 5'd8;
      res_o.ol   = '0;
      if (long9) begin
        res_o.need = 5'd9;
        res_o.oh   = {hi_i[55:0], lo_i[63:56]} ^ SIGN64;
      end else begin
        res_o.need = {1'b0, dec_nb};
        res_o.oh   = dv;
      end
    end else begin
      res_o.need = 5'd8;
      if (enc_nb == 4'd9) begin
        res_o.olen = 5'd9;
        res_o.oh   = {{8{~neg}}, w9[63:8]};
        res_o.ol   = {w9[7:0], 56'd0};
      end else begin
        res_o.olen = {1'b0, enc_nb};
        res_o.oh   = eoh;
        res_o.ol   = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tkc_codec.sv =====
`default_nettype none

module tkc_codec (
  input  tkc_pkg::in_t  cmd_i,
  output tkc_pkg::out_t res_o
);
  import tkc_pkg::*;

  long_res_t        long_res;
  logic             dec;
  logic [WordW-1:0] hi;
  logic [WordW-1:0] lo;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  need;
  logic [LenW-1:0]  olen;
  logic [WordW-1:0] oh;
  logic [WordW-1:0] ol;
  logic             bad;
  logic             neg;
  logic [3:0]       ver;
  logic [127:0]     keep;

  assign dec = (cmd_i.direction == DIR_DECODE);
  assign hi  = cmd_i.in_hi;
  assign lo  = cmd_i.in_lo;

  tkc_long u_long (
    .hi_i  (hi),
    .lo_i  (lo),
    .dec_i (dec),
    .res_o (long_res)
  );

  always_comb begin
    len  = (cmd_i.in_length > MAX_BYTES) ? MAX_BYTES : cmd_i.in_length;
    need = '0;
    olen = '0;
    oh   = '0;
    ol   = '0;
    bad  = 1'b0;
    neg  = hi[63] ^ dec;
    ver  = '0;
    unique case (mode_e'(cmd_i.mode))
      MODE_BOOL: begin
        need = 5'd1;
        olen = 5'd1;
        if (dec) begin
          oh = hi;
        end else begin
          oh = (hi[63:56] != 8'd0) ? (64'd1 << 56) : '0;
        end
      end
      MODE_I8: begin
        need = 5'd1;
        olen = 5'd1;
        oh   = hi ^ SIGN64;
      end
      MODE_I16: begin
        need = 5'd2;
        olen = 5'd2;
        oh   = hi ^ SIGN64;
      end
      MODE_I32: begin
        need = 5'd4;
        olen = 5'd4;
        oh   = hi ^ SIGN64;
      end
      MODE_I64: begin
        need = 5'd8;
        olen = 5'd8;
        oh   = hi ^ SIGN64;
      end
      MODE_LONG: begin
        need = long_res.need;
        olen = long_res.olen;
        oh   = long_res.oh;
        ol   = long_res.ol;
      end
      MODE_FLOAT: begin
        need = 5'd4;
        olen = 5'd4;
        oh   = hi ^ (neg ? 64'hFFFF_FFFF_0000_0000 : SIGN64);
      end
      MODE_DOUBLE: begin
        need = 5'd8;
        olen = 5'd8;
        oh   = hi ^ (neg ? {WordW{1'b1}} : SIGN64);
      end
      MODE_PASS4: begin
        need = 5'd4;
        olen = 5'd4;
        oh   = hi;
      end
      MODE_PASS8: begin
        need = 5'd8;
        olen = 5'd8;
        oh   = hi;
      end
      MODE_UUID: begin
        need = 5'd16;
        olen = 5'd16;
        ol   = lo;
        if (!dec) begin
          ver = hi[15:12];
          if (ver == 4'd1) begin
            oh = msb_to_cmp(hi);
          end else begin
            oh = {ver, 60'd0} | ((hi >> 4) & UUID_MID_MASK) | (hi & 64'hFFF);
          end
        end else begin
          ver = hi[63:60];
          if (ver == 4'd1) begin
            oh = msb_from_cmp(hi);
          end else begin
            oh = ((hi << 4) & 64'hFFFF_FFFF_FFFF_0000) | {48'd0, ver, 12'd0}
               | (hi & 64'hFFF);
          end
        end
      end
      MODE_TIMEUUID: begin
        need = 5'd16;
        olen = 5'd16;
        oh   = dec ? msb_from_cmp(hi) : msb_to_cmp(hi);
        ol   = lo ^ BYTE_FLIPS;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (len < need) begin
      bad = 1'b1;
    end
  end

  // left-aligned byte mask over both words
  assign keep = ~({128{1'b1}} >> {olen, 3'b000});

  always_comb begin
    if (bad) begin
      res_o.out_hi     = '0;
      res_o.out_lo     = '0;
      res_o.out_length = '0;
      res_o.status     = STATUS_SHORT;
    end else begin
      res_o.out_hi     = oh & keep[127:64];
      res_o.out_lo     = ol & keep[63:0];
      res_o.out_length = olen;
      res_o.status     = STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/typed_key_comparable_codec_core.sv =====
// Channel   Ports                     Beat moves when
// -------   -----------------------   --------------------------
// command   start, busy, cmd_i        start high and busy low
// result    done_o, result_o          done_o high (one cycle)
//
// Every command gives one result; the path from its accept edge has one
// register on the command, one on the result, mode decode and byte
// shuffling in between. busy never rises, so a command can enter every
// cycle. rst_ni clears the stage valid flags asynchronously. The receiver
// cannot stall; each result stands for exactly one cycle.
`default_nettype none

module typed_key_comparable_codec_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tkc_pkg::in_t  cmd_i,
  output logic          done_o,
  output tkc_pkg::out_t result_o
);
  import tkc_pkg::*;

  logic  cmd_vld_q;
  logic  cmd_vld_d;
  in_t   cmd_q;
  logic  done_q;
  logic  done_d;
  out_t  res_q;
  out_t  res_d;

  assign busy      = 1'b0;
  assign cmd_vld_d = start && !busy;
  assign done_d    = cmd_vld_q;

  tkc_codec u_codec (
    .cmd_i (cmd_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_d) begin
      cmd_q <= cmd_i;
    end
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== tb/tb_typed_key_comparable_codec_core.sv =====
module tb_typed_key_comparable_codec_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tkc_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200_000;
  localparam int unsigned MAX_REPORTS      = 200;
  localparam logic [3:0]  FIRST_UNUSED_MODE = 4'(MODE_TIMEUUID + 1);
  localparam logic [3:0]  LAST_UNUSED_MODE  = 4'hF;
  localparam logic [3:0]  UUID_TIME_VERSION = 4'd1;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  in_t  cmd    = '0;
  logic done;
  out_t result;

  out_t        expected_q[$];
  int unsigned idle_pct      = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;

  typed_key_comparable_codec_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd),
    .done_o  (done),
    .result_o(result)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected comparable / serialized form of one command.
  function automatic out_t predict_key_codec(in_t c);
    logic [63:0] hi, lo, oh, ol, neg_mask, ev, w, v;
    logic [7:0]  mask, x;
    int unsigned len, need, olen, nb, bits;
    logic        dec, pos, is_neg, short_in;
    out_t        r;
    hi       = c.in_hi;
    lo       = c.in_lo;
    dec      = (c.direction == DIR_DECODE);
    len      = (c.in_length > MAX_BYTES) ? MAX_BYTES : c.in_length;
    oh       = '0;
    ol       = '0;
    need     = 0;
    olen     = 0;
    short_in = 1'b0;
    is_neg   = hi[63] ^ dec;
    case (c.mode)
      MODE_BOOL: begin
        need = 1; olen = 1;
        oh = dec ? hi : {7'b0, |hi[63:56], 56'b0};
      end
      MODE_I8:  begin need = 1; olen = 1; oh = hi ^ SIGN64; end
      MODE_I16: begin need = 2; olen = 2; oh = hi ^ SIGN64; end
      MODE_I32: begin need = 4; olen = 4; oh = hi ^ SIGN64; end
      MODE_I64: begin need = 8; olen = 8; oh = hi ^ SIGN64; end
      MODE_LONG: begin
        if (!dec) begin
          neg_mask = {64{hi[63]}};
          ev       = hi ^ neg_mask;
          bits     = 1;
          for (int i = 0; i < 64; i++) if (ev[i]) bits = i + 1;
          nb   = bits / 7 + 1;
          need = 8;
          if (nb >= 9) begin
            w    = (ev | SIGN64) ^ neg_mask;
            oh   = {~neg_mask[7:0], w[63:8]};
            ol   = {w[7:0], 56'b0};
            olen = 9;
          end else begin
            mask = 8'hFF << (8 - nb);
            w    = (ev | (64'(mask) << (8 * nb - 8))) ^ neg_mask;
            oh   = w << (64 - 8 * nb);
            olen = nb;
          end
        end else begin
          pos  = hi[63];
          x    = hi[63:56] ^ {8{pos}};
          nb   = 8;
          for (int i = 0; i < 8; i++) if (x[i]) nb = 7 - i;
          olen = 8;
          if (len == 0) begin
            short_in = 1'b1;
          end else if (nb == 8 && hi[55] == pos) begin
            // nine-byte form: full 64-bit value follows the header byte
            need = 9;
            oh   = {hi[55:0], lo[63:56]} ^ SIGN64;
          end else begin
            mask = 8'hFF << (8 - nb);
            v    = hi >> (64 - 8 * nb);
            need = nb;
            v    = v ^ (64'(mask) << (8 * nb - 8));
            if (!pos && nb < 8) v = v | (~64'd0 << (8 * nb));
            oh   = v;
          end
        end
      end
      MODE_FLOAT: begin
        need = 4; olen = 4;
        oh = hi ^ (is_neg ? 64'hFFFF_FFFF_0000_0000 : SIGN64);
      end
      MODE_DOUBLE: begin
        need = 8; olen = 8;
        oh = hi ^ (is_neg ? ~64'd0 : SIGN64);
      end
      MODE_PASS4: begin need = 4; olen = 4; oh = hi; end
      MODE_PASS8: begin need = 8; olen = 8; oh = hi; end
      MODE_UUID: begin
        need = 16; olen = 16; ol = lo;
        if (!dec) begin
          if (hi[15:12] == UUID_TIME_VERSION) oh = {hi[15:0], hi[31:16], hi[63:32]};
          else oh = {hi[15:12], 60'b0} | ((hi >> 4) & UUID_MID_MASK) | {52'b0, hi[11:0]};
        end else begin
          if (hi[63:60] == UUID_TIME_VERSION) oh = {hi[31:0], hi[47:32], hi[63:48]};
          else oh = ((hi << 4) & 64'hFFFF_FFFF_FFFF_0000) | {48'b0, hi[63:60], hi[11:0]};
        end
      end
      MODE_TIMEUUID: begin
        need = 16; olen = 16;
        oh = dec ? {hi[31:0], hi[47:32], hi[63:48]} : {hi[15:0], hi[31:16], hi[63:32]};
        ol = lo ^ BYTE_FLIPS;
      end
      default: short_in = 1'b1;
    endcase
    if (len < need) short_in = 1'b1;
    r = '0;
    if (short_in) begin
      r.status = STATUS_SHORT;
    end else begin
      r.out_hi     = (olen >= 8) ? oh : oh & ~(~64'd0 >> (8 * olen));
      r.out_lo     = (olen <= 8) ? 64'd0 :
                     (olen >= 16) ? ol : ol & ~(~64'd0 >> (8 * (olen - 8)));
      r.out_length = olen[4:0];
      r.status     = STATUS_OK;
    end
    return r;
  endfunction

  function automatic in_t make_cmd(input logic [3:0] mode, input logic dir,
                                   input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [4:0] len);
    in_t c;
    c.mode      = mode;
    c.direction = dir;
    c.in_hi     = hi;
    c.in_lo     = lo;
    c.in_length = len;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // One command beat; start stays high for a following back-to-back beat.
  task automatic send_cmd(input in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(predict_key_codec(c));
    sent_count++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h", result));
      end else begin
        want = expected_q.pop_front();
        checked_count++;
        if (result.out_hi !== want.out_hi)
          report_mismatch($sformatf("out_hi %h, want %h", result.out_hi, want.out_hi));
        if (result.out_lo !== want.out_lo)
          report_mismatch($sformatf("out_lo %h, want %h", result.out_lo, want.out_lo));
        if (result.out_length !== want.out_length)
          report_mismatch($sformatf("out_length %0d, want %0d",
                                    result.out_length, want.out_length));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %b, want %b", result.status, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every type in both directions, all-zero and all-one data alternating.
  task automatic test_type_sweep();
    logic [63:0] pattern;
    for (int m = MODE_BOOL; m <= MODE_TIMEUUID; m++) begin
      for (int d = DIR_ENCODE; d <= DIR_DECODE; d++) begin
        pattern = ((m + d) % 2 != 0) ? ~64'd0 : 64'd0;
        send_cmd(make_cmd(4'(m), 1'(d), pattern, ~pattern, MAX_BYTES));
      end
    end
  endtask

  task automatic test_corner_cases();
    logic [63:0] r;
    r = {$urandom, $urandom};
    send_cmd(make_cmd(MODE_LONG, DIR_ENCODE, SIGN64, 64'd0, 5'd8));     // most negative
    send_cmd(make_cmd(MODE_LONG, DIR_ENCODE, 64'd63, r, 5'd8));         // widest 1-byte
    send_cmd(make_cmd(MODE_LONG, DIR_DECODE, r, r, 5'd0));              // empty input
    send_cmd(make_cmd(MODE_I64, DIR_ENCODE, r, r, 5'd7));               // one byte short
    send_cmd(make_cmd(MODE_UUID, DIR_ENCODE, {r[63:16], UUID_TIME_VERSION, r[11:0]},
                      ~r, MAX_BYTES));
    send_cmd(make_cmd(LAST_UNUSED_MODE, DIR_DECODE, r, r, MAX_BYTES));
    send_cmd(make_cmd(MODE_FLOAT, DIR_DECODE, r, r, 5'd31));            // length above 16
  endtask

  task automatic make_random_cmd(output in_t c);
    in_t         enc;
    out_t        fwd;
    logic [63:0] value;
    int unsigned need, sel;
    c.mode      = 4'($urandom_range(MODE_TIMEUUID, MODE_BOOL));
    if ($urandom_range(11) == 0)
      c.mode = 4'($urandom_range(LAST_UNUSED_MODE, FIRST_UNUSED_MODE));
    c.direction = 1'($urandom_range(1));
    c.in_hi     = {$urandom, $urandom};
    c.in_lo     = {$urandom, $urandom};
    case (c.mode)
      MODE_BOOL, MODE_I8:                need = 1;
      MODE_I16:                          need = 2;
      MODE_I32, MODE_FLOAT, MODE_PASS4:  need = 4;
      MODE_I64, MODE_DOUBLE, MODE_PASS8: need = 8;
      MODE_LONG:                         need = (c.direction == DIR_DECODE) ? 1 : 8;
      default:                           need = 16;
    endcase
    if (c.mode == MODE_LONG) begin
      // spread magnitudes so every code length shows up
      value = {$urandom, $urandom} >> $urandom_range(63);
      if ($urandom_range(1)) value = ~value;
      if (c.direction == DIR_ENCODE) begin
        c.in_hi = value;
      end else if ($urandom_range(3) != 0) begin
        enc     = make_cmd(MODE_LONG, DIR_ENCODE, value, 64'd0, MAX_BYTES);
        fwd     = predict_key_codec(enc);
        c.in_hi = fwd.out_hi;
        c.in_lo = fwd.out_lo;
        need    = fwd.out_length;
      end
    end
    if (c.mode == MODE_UUID && $urandom_range(1)) begin
      if (c.direction == DIR_ENCODE) c.in_hi[15:12] = UUID_TIME_VERSION;
      else c.in_hi[63:60] = UUID_TIME_VERSION;
    end
    sel = $urandom_range(9);
    if (sel < 7) c.in_length = 5'($urandom_range(MAX_BYTES, need));
    else if (sel == 7) c.in_length = 5'(need - 1);
    else c.in_length = 5'($urandom_range(31));
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
    in_t c;
    idle_pct = pct;
    repeat (count) begin
      make_random_cmd(c);
      send_cmd(c);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 16;
    test_type_sweep();
    test_corner_cases();
    test_random_traffic(16, 420);
    test_random_traffic(83, 415);
    test_random_traffic(0, 415);

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Sent %0d commands: all types both ways, unused types, short and oversize",
             sent_count);
    $display("lengths, long-code round trips; %0d results checked, %0d mismatches",
             checked_count, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tkc_pkg.sv
hdl/tkc_long.sv
hdl/tkc_codec.sv
hdl/typed_key_comparable_codec_core.sv
tb/tb_typed_key_comparable_codec_core.sv
